FILE: hw/rtl/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants of the lidar point filter
// Coordinate and counter widths, drop reason codes, register indexes, the
// configuration bundle and the word format of the front-to-back queue.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Widths
  localparam int COORD_BITS = 19;
  localparam int COUNT_BITS = 24;
  localparam int RANGE_BITS = COORD_BITS - 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int LIM_BITS   = 2 * RANGE_BITS;
  localparam int OFF_BITS   = 35;
  localparam int TIME_BITS  = 36;

  // Configuration port
  localparam int DATA_BITS    = 64;
  localparam int ADDR_BITS    = 6;
  localparam int REG_IDX_BITS = 3;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  // Saturation limit of the counters
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Timestamp offset clamp, +/- 2^33 ns
  localparam logic signed [63:0] OFF_LIMIT = 64'sd8589934592;

  // Drop reasons
  localparam logic [2:0] REASON_KEPT    = 3'd0;
  localparam logic [2:0] REASON_INVALID = 3'd1;
  localparam logic [2:0] REASON_NULL    = 3'd2;
  localparam logic [2:0] REASON_RANGE   = 3'd3;
  localparam logic [2:0] REASON_NOISE   = 3'd4;

  // Noise check
  localparam logic [1:0] NOISE_MASK      = 2'b11;
  localparam logic [2:0] NOISE_OFF_LIMIT = 3'd3;
  localparam logic [2:0] NOISE_RESET     = 3'd4;

  // Register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_NULL_X      = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_NULL_Y      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_NULL_Z      = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_NULL_RADIUS = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_RANGE   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_RANGE   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_NOISE       = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_TIME_OFFSET = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] null_x;
    logic signed [COORD_BITS-1:0] null_y;
    logic signed [COORD_BITS-1:0] null_z;
    logic [RANGE_BITS-1:0]        sphere_radius;
    logic [RANGE_BITS-1:0]        range_floor;
    logic [RANGE_BITS-1:0]        range_ceil;
    logic [2:0]                   noise_threshold;
    logic signed [63:0]           frame_time_offset;
  } cfg_t;

  // One classified point as it waits in the queue
  typedef struct packed {
    logic [2:0]            reason;
    logic                  first;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [7:0]            refl;
    logic [7:0]            tag;
    logic [7:0]            ring;
    logic [31:0]           rel_time;
  } queue_word_t;

  // Queue status toward the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: hw/rtl/lpf_front.sv
// ----------------------------------------------------------------------------
// lpf_front: point intake and classification pipeline
// Three register stages (capture, magnitudes and timestamp, squares) and a
// final compare that pushes one classified word into the queue.
// ----------------------------------------------------------------------------
module lpf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  lpf_pkg::cfg_t                       cfg,
  input  logic                                point_valid,
  output logic                                point_ready,
  input  logic                                first_in_frame,
  input  logic                                coords_invalid,
  input  logic signed [lpf_pkg::COORD_BITS-1:0] x_mm,
  input  logic signed [lpf_pkg::COORD_BITS-1:0] y_mm,
  input  logic signed [lpf_pkg::COORD_BITS-1:0] z_mm,
  input  logic [7:0]                          reflectivity,
  input  logic [7:0]                          point_tag,
  input  logic [7:0]                          scan_line,
  input  logic [31:0]                         point_time,
  input  lpf_pkg::queue_status_t              q_status,
  output logic                                push,
  output lpf_pkg::queue_word_t                push_word
);

  localparam int CB = lpf_pkg::COORD_BITS;
  localparam int DB = lpf_pkg::DIFF_BITS;
  localparam int SB = lpf_pkg::SQ_BITS;
  localparam int UB = lpf_pkg::SUM_BITS;
  localparam int LB = lpf_pkg::LIM_BITS;
  localparam int OB = lpf_pkg::OFF_BITS;
  localparam int TB = lpf_pkg::TIME_BITS;

  // Magnitude of a signed difference
  function automatic logic [DB-1:0] mag(input logic signed [DB-1:0] d);
    logic signed [DB-1:0] n;
    n = -d;
    mag = d[DB-1] ? DB'(n) : DB'(d);
  endfunction

  // Difference of two coordinates, one bit wider
  function automatic logic signed [DB-1:0] diff(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    logic signed [DB-1:0] ae;
    logic signed [DB-1:0] be;
    ae = DB'(a);
    be = DB'(b);
    diff = ae - be;
  endfunction

  // Derived limits, refreshed every cycle from the configuration
  logic [LB-1:0]        lim_null;
  logic [LB-1:0]        lim_min;
  logic [LB-1:0]        lim_max;
  logic signed [OB-1:0] off_clamp;

  always_ff @(posedge clk) begin
    lim_null <= LB'(cfg.sphere_radius) * LB'(cfg.sphere_radius);
    lim_min  <= LB'(cfg.range_floor) * LB'(cfg.range_floor);
    lim_max  <= LB'(cfg.range_ceil) * LB'(cfg.range_ceil);
    if (cfg.frame_time_offset > lpf_pkg::OFF_LIMIT) begin
      off_clamp <= OB'(lpf_pkg::OFF_LIMIT);
    end else if (cfg.frame_time_offset < -lpf_pkg::OFF_LIMIT) begin
      off_clamp <= OB'(-lpf_pkg::OFF_LIMIT);
    end else begin
      off_clamp <= OB'(cfg.frame_time_offset);
    end
  end

  // Pipeline advances unless the last stage is blocked by a full queue
  logic v1, v2, v3;
  logic en;

  assign en          = !(v3 && q_status.full);
  assign point_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= point_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: capture
  logic                 first1, inv1;
  logic signed [CB-1:0] x1, y1, z1;
  logic [7:0]           refl1, tag1, ring1;
  logic [31:0]          ot1;

  always_ff @(posedge clk) begin
    if (en) begin
      first1 <= first_in_frame;
      inv1   <= coords_invalid;
      x1     <= x_mm;
      y1     <= y_mm;
      z1     <= z_mm;
      refl1  <= reflectivity;
      tag1   <= point_tag;
      ring1  <= scan_line;
      ot1    <= point_time;
    end
  end

  // Stage 2: magnitudes and saturated timestamp
  logic signed [TB-1:0] t_sum;
  logic [31:0]          t_sat;

  always_comb begin
    t_sum = TB'(off_clamp) + $signed({{(TB-32){1'b0}}, ot1});
    if (t_sum[TB-1:31] != {(TB-31){t_sum[TB-1]}}) begin
      t_sat = t_sum[TB-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      t_sat = t_sum[31:0];
    end
  end

  logic            first2, inv2;
  logic [CB-1:0]   x2, y2, z2;
  logic [7:0]      refl2, tag2, ring2;
  logic [31:0]     rel2;
  logic [DB-1:0]   ad2 [3];
  logic [DB-1:0]   ar2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      first2 <= first1;
      inv2   <= inv1;
      x2     <= x1;
      y2     <= y1;
      z2     <= z1;
      refl2  <= refl1;
      tag2   <= tag1;
      ring2  <= ring1;
      rel2   <= t_sat;
      ad2[0] <= mag(diff(x1, cfg.null_x));
      ad2[1] <= mag(diff(y1, cfg.null_y));
      ad2[2] <= mag(diff(z1, cfg.null_z));
      ar2[0] <= mag(DB'(x1));
      ar2[1] <= mag(DB'(y1));
      ar2[2] <= mag(DB'(z1));
    end
  end

  // Stage 3: squares
  logic            first3, inv3;
  logic [CB-1:0]   x3, y3, z3;
  logic [7:0]      refl3, tag3, ring3;
  logic [31:0]     rel3;
  logic [SB-1:0]   sd3 [3];
  logic [SB-1:0]   sr3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      first3 <= first2;
      inv3   <= inv2;
      x3     <= x2;
      y3     <= y2;
      z3     <= z2;
      refl3  <= refl2;
      tag3   <= tag2;
      ring3  <= ring2;
      rel3   <= rel2;
      for (int i = 0; i < 3; i++) begin
        sd3[i] <= SB'(ad2[i]) * SB'(ad2[i]);
        sr3[i] <= SB'(ar2[i]) * SB'(ar2[i]);
      end
    end
  end

  // Stage 4: sums, tests in fixed order, push
  logic [UB-1:0] sum_d, sum_r;
  logic          near_null, too_close, too_far, noisy;
  logic [2:0]    reason;

  always_comb begin
    sum_d     = UB'(sd3[0]) + UB'(sd3[1]) + UB'(sd3[2]);
    sum_r     = UB'(sr3[0]) + UB'(sr3[1]) + UB'(sr3[2]);
    near_null = (cfg.sphere_radius != '0) && (sum_d <= UB'(lim_null));
    too_close = (cfg.range_floor != '0) && (sum_r < UB'(lim_min));
    too_far   = (cfg.range_ceil != '0) && (sum_r > UB'(lim_max));
    noisy     = (cfg.noise_threshold <= lpf_pkg::NOISE_OFF_LIMIT) &&
                ({1'b0, tag3[1:0] & lpf_pkg::NOISE_MASK} >= cfg.noise_threshold);
    if (inv3) begin
      reason = lpf_pkg::REASON_INVALID;
    end else if (near_null) begin
      reason = lpf_pkg::REASON_NULL;
    end else if (too_close || too_far) begin
      reason = lpf_pkg::REASON_RANGE;
    end else if (noisy) begin
      reason = lpf_pkg::REASON_NOISE;
    end else begin
      reason = lpf_pkg::REASON_KEPT;
    end
  end

  assign push               = v3 && !q_status.full;
  assign push_word.reason   = reason;
  assign push_word.first    = first3;
  assign push_word.x        = x3;
  assign push_word.y        = y3;
  assign push_word.z        = z3;
  assign push_word.refl     = refl3;
  assign push_word.tag      = tag3;
  assign push_word.ring     = ring3;
  assign push_word.rel_time = rel3;

endmodule

FILE: hw/rtl/lpf_queue.sv
// ----------------------------------------------------------------------------
// lpf_queue: short word queue between front and back
// Register-based FIFO, one push and one pop per cycle, head word shown
// directly at the output.
// ----------------------------------------------------------------------------
module lpf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lpf_pkg::queue_word_t   push_word,
  input  logic                   pop,
  output lpf_pkg::queue_word_t   head_word,
  output lpf_pkg::queue_status_t q_status
);

  localparam int PB = lpf_pkg::QPTR_BITS;
  localparam int NB = lpf_pkg::QCNT_BITS;

  lpf_pkg::queue_word_t slots [lpf_pkg::QUEUE_DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [NB-1:0] count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PB'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NB'(1);
        2'b01:   count <= count - NB'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  assign head_word      = slots[rd_ptr];
  assign q_status.full  = (count == NB'(lpf_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

endmodule

FILE: hw/rtl/lpf_back.sv
// ----------------------------------------------------------------------------
// lpf_back: frame counters and result output register
// Pops one classified word per cycle unless the queue is empty or the output
// stalls; updates per-frame seen and kept counts, holds the result till taken.
// ----------------------------------------------------------------------------
module lpf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  lpf_pkg::queue_status_t              q_status,
  input  lpf_pkg::queue_word_t                head_word,
  output logic                                pop,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [2:0]                          drop_reason,
  output logic signed [lpf_pkg::COORD_BITS-1:0] out_x,
  output logic signed [lpf_pkg::COORD_BITS-1:0] out_y,
  output logic signed [lpf_pkg::COORD_BITS-1:0] out_z,
  output logic [7:0]                          intensity,
  output logic signed [31:0]                  rel_time_ns,
  output logic [7:0]                          ring,
  output logic [7:0]                          out_tag,
  output logic [lpf_pkg::COUNT_BITS-1:0]      points_seen,
  output logic [lpf_pkg::COUNT_BITS-1:0]      points_kept
);

  localparam int KB = lpf_pkg::COUNT_BITS;

  logic          load;
  logic [KB-1:0] seen_base, kept_base, seen_next, kept_next;

  // Load the output register whenever it is free or being emptied
  assign load = !q_status.empty && (!result_valid || result_ready);
  assign pop  = load;

  // Frame start clears, counts saturate at all ones
  always_comb begin
    seen_base = head_word.first ? '0 : points_seen;
    kept_base = head_word.first ? '0 : points_kept;
    seen_next = (seen_base == lpf_pkg::COUNT_MAX) ? seen_base : seen_base + KB'(1);
    if (head_word.reason == lpf_pkg::REASON_KEPT && kept_base != lpf_pkg::COUNT_MAX) begin
      kept_next = kept_base + KB'(1);
    end else begin
      kept_next = kept_base;
    end
  end

  // Counters, which double as the count fields of the result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      points_seen  <= '0;
      points_kept  <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        points_seen  <= seen_next;
        points_kept  <= kept_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      drop_reason <= head_word.reason;
      out_x       <= head_word.x;
      out_y       <= head_word.y;
      out_z       <= head_word.z;
      intensity   <= head_word.refl;
      rel_time_ns <= head_word.rel_time;
      ring        <= head_word.ring;
      out_tag     <= head_word.tag;
    end
  end

endmodule

FILE: hw/rtl/lidar_point_filter_core.sv
// ----------------------------------------------------------------------------
// lidar_point_filter_core: lidar point crop and noise filter
// Point channel (point_valid/point_ready) takes one point per word; result
// channel (result_valid/result_ready) gives one classified word per point,
// in order, with drop reason, passed fields, timestamp and frame counts.
// Registers sit on an APB-style port, 64-bit data, register i at 8*i.
// Throughput is one point per cycle while point_ready is high. A point passes
// capture, magnitudes and squares registers, then the compare stage writes a
// 4-word queue that feeds the output register, which raises result_valid.
// When the receiver stalls, the output register holds, the queue fills and
// point_ready drops once the queue is full with a word waiting behind it;
// up to 8 points may be in flight. Reset empties the pipeline and queue,
// clears the counters and sets all registers to 0, noise threshold to 4.
// The user must write registers while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module lidar_point_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpf_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [lpf_pkg::DATA_BITS-1:0]       pwdata,
  output logic [lpf_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready,
  // points
  input  logic                                point_valid,
  output logic                                point_ready,
  input  logic                                first_in_frame,
  input  logic                                coords_invalid,
  input  logic signed [lpf_pkg::COORD_BITS-1:0] x_mm,
  input  logic signed [lpf_pkg::COORD_BITS-1:0] y_mm,
  input  logic signed [lpf_pkg::COORD_BITS-1:0] z_mm,
  input  logic [7:0]                          reflectivity,
  input  logic [7:0]                          point_tag,
  input  logic [7:0]                          scan_line,
  input  logic [31:0]                         point_time,
  // results
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [2:0]                          drop_reason,
  output logic signed [lpf_pkg::COORD_BITS-1:0] out_x,
  output logic signed [lpf_pkg::COORD_BITS-1:0] out_y,
  output logic signed [lpf_pkg::COORD_BITS-1:0] out_z,
  output logic [7:0]                          intensity,
  output logic signed [31:0]                  rel_time_ns,
  output logic [7:0]                          ring,
  output logic [7:0]                          out_tag,
  output logic [lpf_pkg::COUNT_BITS-1:0]      points_seen,
  output logic [lpf_pkg::COUNT_BITS-1:0]      points_kept
);

  localparam int CB = lpf_pkg::COORD_BITS;
  localparam int RB = lpf_pkg::RANGE_BITS;
  localparam int DW = lpf_pkg::DATA_BITS;

  lpf_pkg::cfg_t cfg;
  logic          cfg_wr;
  logic [lpf_pkg::REG_IDX_BITS-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[lpf_pkg::ADDR_BITS-1:3];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.null_x            <= '0;
      cfg.null_y            <= '0;
      cfg.null_z            <= '0;
      cfg.sphere_radius     <= '0;
      cfg.range_floor       <= '0;
      cfg.range_ceil        <= '0;
      cfg.noise_threshold   <= lpf_pkg::NOISE_RESET;
      cfg.frame_time_offset <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lpf_pkg::REG_NULL_X:      cfg.null_x            <= pwdata[CB-1:0];
        lpf_pkg::REG_NULL_Y:      cfg.null_y            <= pwdata[CB-1:0];
        lpf_pkg::REG_NULL_Z:      cfg.null_z            <= pwdata[CB-1:0];
        lpf_pkg::REG_NULL_RADIUS: cfg.sphere_radius     <= pwdata[RB-1:0];
        lpf_pkg::REG_MIN_RANGE:   cfg.range_floor       <= pwdata[RB-1:0];
        lpf_pkg::REG_MAX_RANGE:   cfg.range_ceil        <= pwdata[RB-1:0];
        lpf_pkg::REG_NOISE:       cfg.noise_threshold   <= pwdata[2:0];
        lpf_pkg::REG_TIME_OFFSET: cfg.frame_time_offset <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (cfg_idx)
      lpf_pkg::REG_NULL_X:      prdata = DW'(unsigned'(cfg.null_x));
      lpf_pkg::REG_NULL_Y:      prdata = DW'(unsigned'(cfg.null_y));
      lpf_pkg::REG_NULL_Z:      prdata = DW'(unsigned'(cfg.null_z));
      lpf_pkg::REG_NULL_RADIUS: prdata = DW'(cfg.sphere_radius);
      lpf_pkg::REG_MIN_RANGE:   prdata = DW'(cfg.range_floor);
      lpf_pkg::REG_MAX_RANGE:   prdata = DW'(cfg.range_ceil);
      lpf_pkg::REG_NOISE:       prdata = DW'(cfg.noise_threshold);
      lpf_pkg::REG_TIME_OFFSET: prdata = cfg.frame_time_offset;
      default:                  prdata = '0;
    endcase
  end

  // Front, queue, back
  lpf_pkg::queue_status_t q_status;
  lpf_pkg::queue_word_t   push_word, head_word;
  logic                   push, pop;

  lpf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .point_valid    (point_valid),
    .point_ready    (point_ready),
    .first_in_frame (first_in_frame),
    .coords_invalid (coords_invalid),
    .x_mm           (x_mm),
    .y_mm           (y_mm),
    .z_mm           (z_mm),
    .reflectivity   (reflectivity),
    .point_tag      (point_tag),
    .scan_line      (scan_line),
    .point_time     (point_time),
    .q_status       (q_status),
    .push           (push),
    .push_word      (push_word)
  );

  lpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_status  (q_status)
  );

  lpf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head_word    (head_word),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drop_reason  (drop_reason),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .intensity    (intensity),
    .rel_time_ns  (rel_time_ns),
    .ring         (ring),
    .out_tag      (out_tag),
    .points_seen  (points_seen),
    .points_kept  (points_kept)
  );

  // Checks
  a_kept_le_seen: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (points_kept <= points_seen))
    else $error("kept count exceeds seen count");

  a_seen_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (points_seen != '0))
    else $error("result shown with zero seen count");

  a_reason_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (drop_reason <= lpf_pkg::REASON_NOISE))
    else $error("drop reason out of range");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |=> !(result_valid && !$past(result_valid) && !$past(pop)))
    else $error("result appeared without a queue pop");

endmodule
